@@ hdl/tcl_pkg.sv @@
// Package for the tapered clip limiter: payload words, sequencer states,
// divider request and response, fixed-point constants.
// No dependencies.
package tcl_pkg;

    localparam int MAX_TAPER_DEF = 16;
    localparam int SAMPLE_W      = 16;
    localparam int TAPER_W       = 5;
    localparam int DIVIDEND_W    = 28;
    localparam int DIVISOR_W     = 16;
    localparam int RATIO_W       = 16;

    localparam logic [TAPER_W-1:0]           TAPER_RESET = 5'd2;
    localparam logic signed [SAMPLE_W-1:0]   UNITY_POS   = 16'sd4096;
    localparam logic signed [SAMPLE_W-1:0]   UNITY_NEG   = -16'sd4096;
    localparam logic [DIVIDEND_W-1:0]        RECIP_NUM   = 28'h800_0000;
    localparam logic [RATIO_W:0]             UNITY_Q15   = 17'h0_8000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       block_end;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       is_last;
    } out_word_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_EX_CHECK,
        BK_EX_READ,
        BK_DIV_R,
        BK_DIV_INC,
        BK_NB_STEP,
        BK_NB_A,
        BK_NB_A_DATA,
        BK_NB_A_WR,
        BK_NB_B,
        BK_NB_B_DATA,
        BK_NB_B_WR,
        BK_EM_CHECK,
        BK_EM_READ,
        BK_EM_LOAD,
        BK_FINISH
    } back_state_t;

endpackage

@@ hdl/tapered_clip_limiter.sv @@
// Top level of the tapered clip limiter: taper register, input queue,
// window sequencer and shared divider. Depends on tcl_pkg and submodules.
//
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    in_data (sample_in, block_end)
// out      output     out_valid/out_ready  out_data (sample_out, is_last)
// cfg      input      cfg_valid/cfg_ready  cfg_data (taper_steps)
//
// One item at a time in the sequencer: it examines samples, runs the
// divider twice and tapers the neighbours for each clipped sample, and
// emits words. The serial divider and the single read port of the window
// memory set its pace.
// Reset needs no clearing pass; the window memory is read only where written.
// A stalled output holds the word while the queue takes input until it is full.
module tapered_clip_limiter
    import tcl_pkg::*;
#(
    parameter int MAX_TAPER = MAX_TAPER_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_word_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_word_t          out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [TAPER_W-1:0] cfg_data
);

    logic [TAPER_W-1:0] taper_reg, taper_next;
    logic               q_valid;
    logic               q_ready;
    in_word_t           q_data;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // take config words at any time
    assign cfg_ready  = 1'b1;
    assign taper_next = (cfg_valid && cfg_ready) ? cfg_data : taper_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taper_reg <= TAPER_RESET;
        end
        else
        begin
            taper_reg <= taper_next;
        end
    end

    tcl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    tcl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tcl_back #(
        .MAX_TAPER (MAX_TAPER)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_data      (q_data),
        .taper_steps (taper_reg),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

@@ hdl/tcl_front.sv @@
// Front end: accepts input words and holds them in a two-entry queue
// ahead of the window sequencer. Depends on tcl_pkg.
module tcl_front
    import tcl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_data,
    output logic     q_valid,
    input  logic     q_ready,
    output in_word_t q_data
);

    in_word_t   ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = ent_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // hold the queued words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ hdl/tcl_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by the ratio and
// the taper increment. Depends on tcl_pkg.
module tcl_div
    import tcl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    assign trial = {rem_reg, dvd_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    // shift one bit, subtract where the divisor fits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            dvd_next = {dvd_reg[DIVIDEND_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = dvd_reg;

endmodule

@@ hdl/tcl_back.sv @@
// Back end: window memory and sequencer that appends, clips and tapers
// neighbours, then emits output words. Depends on tcl_pkg and tcl_div.
module tcl_back
    import tcl_pkg::*;
#(
    parameter int MAX_TAPER = MAX_TAPER_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  in_word_t           q_data,
    input  logic [TAPER_W-1:0] taper_steps,
    output div_req_t           div_req,
    input  div_rsp_t           div_rsp,
    output logic               out_valid,
    input  logic               out_ready,
    output out_word_t          out_data
);

    localparam int WIN    = 2 * MAX_TAPER + 1;
    localparam int ADDR_W = $clog2(WIN);
    localparam int CNT_W  = $clog2(WIN + 1);
    localparam int J_W    = $clog2(MAX_TAPER + 2);

    back_state_t state_reg, state_next;

    logic [ADDR_W-1:0]         base_reg, base_next;
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [CNT_W-1:0]          bsd_reg, bsd_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      last_reg, last_next;
    logic [J_W-1:0]            j_reg, j_next;
    logic [RATIO_W-1:0]        r_reg, r_next;
    logic [RATIO_W-1:0]        inc_reg, inc_next;
    logic [ADDR_W-1:0]         nb_addr_reg, nb_addr_next;
    logic signed [32:0]        prod_reg, prod_next;
    logic                      out_valid_reg, out_valid_next;
    out_word_t                 out_reg, out_next;

    logic [SAMPLE_W-1:0]       mem [WIN];
    logic [SAMPLE_W-1:0]       rdata_reg;
    logic                      mem_we, mem_re;
    logic [ADDR_W-1:0]         mem_waddr, mem_raddr;
    logic [SAMPLE_W-1:0]       mem_wdata;

    logic [J_W-1:0]            n_val;
    logic [CNT_W-1:0]          limit;
    logic [CNT_W:0]            two_n;
    logic [CNT_W-1:0]          count;
    logic signed [SAMPLE_W:0]  vx;
    logic signed [SAMPLE_W:0]  magx;
    logic [CNT_W:0]            pos_fwd;
    logic [CNT_W-1:0]          pos_bwd;
    logic [RATIO_W:0]          gap;

    // fold a logical sum back into the circular window
    function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W:0] sum);
        if (sum >= (ADDR_W + 1)'(WIN))
        begin
            wrap_addr = ADDR_W'(sum - (ADDR_W + 1)'(WIN));
        end
        else
        begin
            wrap_addr = sum[ADDR_W-1:0];
        end
    endfunction

    // clamp taper to the window size
    always_comb
    begin
        if (int'(taper_steps) > MAX_TAPER)
        begin
            n_val = J_W'(MAX_TAPER);
        end
        else
        begin
            n_val = J_W'(taper_steps);
        end
    end

    // examine and emit bounds
    always_comb
    begin
        two_n = (CNT_W + 1)'(n_val) + (CNT_W + 1)'(n_val);
        if (last_reg)
        begin
            limit = fill_reg;
        end
        else if (fill_reg > CNT_W'(n_val))
        begin
            limit = fill_reg - CNT_W'(n_val);
        end
        else
        begin
            limit = '0;
        end
        if (last_reg)
        begin
            count = fill_reg;
        end
        else if ((CNT_W + 1)'(fill_reg) > two_n)
        begin
            count = CNT_W'((CNT_W + 1)'(fill_reg) - two_n);
        end
        else
        begin
            count = '0;
        end
        if (count > bsd_reg)
        begin
            count = bsd_reg;
        end
    end

    assign vx      = {rdata_reg[SAMPLE_W-1], rdata_reg};
    assign magx    = vx[SAMPLE_W] ? -vx : vx;
    assign pos_fwd = (CNT_W + 1)'(bsd_reg) + (CNT_W + 1)'(j_reg);
    assign pos_bwd = bsd_reg - CNT_W'(j_reg);
    assign gap     = UNITY_Q15 - {1'b0, div_rsp.quot[RATIO_W-1:0]};

    // sequencer: next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        fill_next      = fill_reg;
        bsd_next       = bsd_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        j_next         = j_reg;
        r_next         = r_reg;
        inc_next       = inc_reg;
        nb_addr_next   = nb_addr_reg;
        prod_next      = prod_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_ready        = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = '0;
        mem_raddr      = '0;
        mem_wdata      = '0;
        div_req        = '0;
        unique case (state_reg)
            BK_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    if (fill_reg < CNT_W'(WIN))
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = wrap_addr((ADDR_W + 1)'(base_reg)
                                              + (ADDR_W + 1)'(fill_reg));
                        mem_wdata = q_data.sample_in;
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    last_next  = q_data.block_end;
                    state_next = BK_EX_CHECK;
                end
            end
            BK_EX_CHECK:
            begin
                if (bsd_reg < limit)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = wrap_addr((ADDR_W + 1)'(base_reg)
                                           + (ADDR_W + 1)'(bsd_reg));
                    state_next = BK_EX_READ;
                end
                else
                begin
                    state_next = BK_EM_CHECK;
                end
            end
            BK_EX_READ:
            begin
                if ((vx > 17'sd4096) || (vx < -17'sd4096))
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = wrap_addr((ADDR_W + 1)'(base_reg)
                                                 + (ADDR_W + 1)'(bsd_reg));
                    mem_wdata        = vx[SAMPLE_W] ? UNITY_NEG : UNITY_POS;
                    div_req.start    = 1'b1;
                    div_req.dividend = RECIP_NUM;
                    div_req.divisor  = magx[DIVISOR_W-1:0];
                    state_next       = BK_DIV_R;
                end
                else
                begin
                    bsd_next   = bsd_reg + CNT_W'(1);
                    state_next = BK_EX_CHECK;
                end
            end
            BK_DIV_R:
            begin
                if (div_rsp.done)
                begin
                    r_next           = div_rsp.quot[RATIO_W-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = DIVIDEND_W'(gap);
                    div_req.divisor  = DIVISOR_W'(n_val) + DIVISOR_W'(1);
                    state_next       = BK_DIV_INC;
                end
            end
            BK_DIV_INC:
            begin
                if (div_rsp.done)
                begin
                    inc_next   = div_rsp.quot[RATIO_W-1:0];
                    j_next     = J_W'(1);
                    state_next = BK_NB_STEP;
                end
            end
            BK_NB_STEP:
            begin
                if (j_reg > n_val)
                begin
                    bsd_next   = bsd_reg + CNT_W'(1);
                    state_next = BK_EX_CHECK;
                end
                else
                begin
                    r_next     = r_reg + inc_reg;
                    state_next = BK_NB_A;
                end
            end
            BK_NB_A:
            begin
                if (pos_fwd < (CNT_W + 1)'(fill_reg))
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = wrap_addr((ADDR_W + 1)'(base_reg)
                                             + (ADDR_W + 1)'(pos_fwd));
                    nb_addr_next = mem_raddr;
                    state_next   = BK_NB_A_DATA;
                end
                else
                begin
                    state_next = BK_NB_B;
                end
            end
            BK_NB_A_DATA:
            begin
                prod_next  = $signed(rdata_reg) * $signed({1'b0, r_reg});
                state_next = BK_NB_A_WR;
            end
            BK_NB_A_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = nb_addr_reg;
                mem_wdata  = prod_reg[30:15];
                state_next = BK_NB_B;
            end
            BK_NB_B:
            begin
                if (CNT_W'(j_reg) <= bsd_reg)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = wrap_addr((ADDR_W + 1)'(base_reg)
                                             + (ADDR_W + 1)'(pos_bwd));
                    nb_addr_next = mem_raddr;
                    state_next   = BK_NB_B_DATA;
                end
                else
                begin
                    j_next     = j_reg + J_W'(1);
                    state_next = BK_NB_STEP;
                end
            end
            BK_NB_B_DATA:
            begin
                prod_next  = $signed(rdata_reg) * $signed({1'b0, r_reg});
                state_next = BK_NB_B_WR;
            end
            BK_NB_B_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = nb_addr_reg;
                mem_wdata  = prod_reg[30:15];
                j_next     = j_reg + J_W'(1);
                state_next = BK_NB_STEP;
            end
            BK_EM_CHECK:
            begin
                cnt_next   = count;
                state_next = BK_EM_READ;
            end
            BK_EM_READ:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = BK_FINISH;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = base_reg;
                    state_next = BK_EM_LOAD;
                end
            end
            BK_EM_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.sample_out = rdata_reg;
                    out_next.is_last    = last_reg && (cnt_reg == CNT_W'(1));
                    out_valid_next      = 1'b1;
                    base_next  = wrap_addr((ADDR_W + 1)'(base_reg) + (ADDR_W + 1)'(1));
                    fill_next  = fill_reg - CNT_W'(1);
                    bsd_next   = bsd_reg - CNT_W'(1);
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = BK_EM_READ;
                end
            end
            BK_FINISH:
            begin
                if (last_reg)
                begin
                    fill_next = '0;
                    bsd_next  = '0;
                end
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            base_reg      <= '0;
            fill_reg      <= '0;
            bsd_reg       <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            fill_reg      <= fill_next;
            bsd_reg       <= bsd_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold datapath values
    always_ff @(posedge clk)
    begin
        r_reg       <= r_next;
        inc_reg     <= inc_next;
        nb_addr_reg <= nb_addr_next;
        prod_reg    <= prod_next;
        out_reg     <= out_next;
    end

    // window memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ hdl/tcl_checker.sv @@
// Port-level checks for the tapered clip limiter, bound to the top level.
// Depends on tcl_pkg.
module tcl_checker
    import tcl_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data,
    input logic      cfg_valid,
    input logic      cfg_ready
);

    // a stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    // config words are never refused
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config word refused");

    // a refused input word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input word dropped while refused");

endmodule

bind tapered_clip_limiter tcl_checker u_tcl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

@@ verif/tapered_clip_limiter_tb.sv @@
// Testbench for the tapered clip limiter: random and directed sample blocks,
// a behavioral window predictor and a field-by-field output checker.
// Depends on tcl_pkg and the tapered_clip_limiter RTL.
module tapered_clip_limiter_tb;
    import tcl_pkg::*;

    localparam int WIN          = 2 * MAX_TAPER_DEF + 1;
    localparam int CYCLE_LIMIT  = 5000000;
    localparam int SETTLE_TICKS = 2000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    in_word_t           in_data;
    logic               out_valid;
    logic               out_ready;
    out_word_t          out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [TAPER_W-1:0] cfg_data;

    // predictor state
    logic [TAPER_W-1:0]         taper_reg;
    logic signed [SAMPLE_W-1:0] win_mem [WIN];
    int                         win_fill;
    int                         exam_pos;

    in_word_t  sample_queue[$];
    out_word_t expected_words[$];
    int        fail_count;
    int        cycle_count;
    bit        feed_enable;
    int        in_gap;
    int        out_gap;

    tapered_clip_limiter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Q15 rescale rounding toward minus infinity
    function automatic logic signed [SAMPLE_W-1:0] rescale(
        logic signed [SAMPLE_W-1:0] d, longint r);
        longint p;
        p = longint'(d) * r;
        return SAMPLE_W'(p >>> 15);
    endfunction

    // Clip one held sample and taper its neighbours
    task automatic clip_at(int pos, int n);
        longint v;
        longint mag;
        longint r;
        longint inc;
        v = win_mem[pos];
        if (v <= 4096 && v >= -4096)
            return;
        mag = v < 0 ? -v : v;
        r = (longint'(1) << 27) / mag;
        inc = (32768 - r) / (n + 1);
        win_mem[pos] = v > 0 ? UNITY_POS : UNITY_NEG;
        for (int j = 1; j <= n; j++)
        begin
            r += inc;
            if (pos + j < win_fill)
                win_mem[pos + j] = rescale(win_mem[pos + j], r);
            if (j <= pos)
                win_mem[pos - j] = rescale(win_mem[pos - j], r);
        end
    endtask

    // Advance the window by one accepted word and queue emitted words
    task automatic predict_word(in_word_t w);
        int n;
        int lim;
        int cnt;
        out_word_t o;
        n = taper_reg > MAX_TAPER_DEF ? MAX_TAPER_DEF : int'(taper_reg);
        if (win_fill < WIN)
        begin
            win_mem[win_fill] = w.sample_in;
            win_fill++;
        end
        lim = w.block_end ? win_fill : (win_fill > n ? win_fill - n : 0);
        while (exam_pos < lim)
        begin
            clip_at(exam_pos, n);
            exam_pos++;
        end
        cnt = w.block_end ? win_fill : (win_fill > 2 * n ? win_fill - 2 * n : 0);
        if (cnt > exam_pos)
            cnt = exam_pos;
        for (int k = 0; k < cnt; k++)
        begin
            o.sample_out = win_mem[k];
            o.is_last    = w.block_end && (k + 1 == cnt);
            expected_words.push_back(o);
        end
        for (int k = 0; k < win_fill - cnt; k++)
            win_mem[k] = win_mem[k + cnt];
        win_fill -= cnt;
        exam_pos -= cnt;
        if (w.block_end)
        begin
            win_fill = 0;
            exam_pos = 0;
        end
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int p;
        p = $urandom_range(0, 9);
        if (p < 4)
            return SAMPLE_W'($urandom_range(0, 8191)) - 16'sd4096;
        if (p < 6)
            return SAMPLE_W'($urandom_range(4097, 32767));
        if (p < 8)
            return -SAMPLE_W'($urandom_range(4097, 32768));
        return SAMPLE_W'($urandom);
    endfunction

    // Queue one block of samples
    task automatic add_block(int len);
        in_word_t w;
        for (int i = 0; i < len; i++)
        begin
            w.sample_in = rand_sample();
            w.block_end = (i == len - 1);
            sample_queue.push_back(w);
        end
    endtask

    task automatic add_word(int s, bit e);
        in_word_t w;
        w.sample_in = SAMPLE_W'(s);
        w.block_end = e;
        sample_queue.push_back(w);
    endtask

    // Write the taper register while the block is idle
    task automatic write_taper(logic [TAPER_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        taper_reg = val;
        cfg_valid <= 1'b0;
    endtask

    // Let the queued words drain through the block
    task automatic drain();
        feed_enable = 1'b1;
        while (sample_queue.size() != 0 || in_valid || expected_words.size() != 0)
            @(posedge clk);
        feed_enable = 1'b0;
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_gap   <= 0;
        end
        else if (in_valid && !in_ready)
        begin
            // hold the word
        end
        else
        begin
            if (in_valid)
                predict_word(in_data);
            if (in_gap > 0)
            begin
                in_gap   <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (feed_enable && sample_queue.size() > 0)
            begin
                in_data  <= sample_queue.pop_front();
                in_valid <= 1'b1;
                in_gap   <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output monitor with random backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word sample_out=%0d is_last=%0d",
                           out_data.sample_out, out_data.is_last);
                    fail_count++;
                end
                else
                begin
                    out_word_t e;
                    e = expected_words.pop_front();
                    if (e.sample_out !== out_data.sample_out)
                    begin
                        $error("sample_out expected %0d actual %0d",
                               e.sample_out, out_data.sample_out);
                        fail_count++;
                    end
                    if (e.is_last !== out_data.is_last)
                    begin
                        $error("is_last expected %0d actual %0d",
                               e.is_last, out_data.is_last);
                        fail_count++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap   <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    out_gap <= pick_gap();
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tapered_clip_limiter_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [TAPER_W-1:0] tapers [6];
        int len;
        tapers = '{5'd0, 5'd31, 5'd16, 5'd1, 5'd7, 5'd17};
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        feed_enable = 1'b0;
        taper_reg   = TAPER_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, both clip signs, edge thresholds, short blocks
        add_word(32767, 0);
        add_word(-32768, 0);
        add_word(4096, 0);
        add_word(4097, 0);
        add_word(-4096, 0);
        add_word(-4097, 0);
        add_word(0, 0);
        add_word(-1, 0);
        add_word(20000, 1);
        add_word(-30000, 1);
        add_word(12000, 0);
        add_word(-12000, 1);
        add_word(1000, 0);
        add_word(8000, 0);
        add_word(-8000, 0);
        add_word(2000, 1);
        drain();

        // random blocks across taper settings, extremes included
        foreach (tapers[t])
        begin
            write_taper(tapers[t]);
            add_word(32767, 0);
            add_word(-32768, 1);
            for (int b = 0; b < 6; b++)
            begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 45)
                                                  : $urandom_range(1, 8);
                add_block(len);
            end
            drain();
        end
        // taper changed between blocks already; end with a mid-block change
        add_block(3);
        sample_queue[$].block_end = 1'b0;
        drain();
        write_taper(5'd3);
        add_block(6);
        drain();

        if (fail_count == 0 && expected_words.size() == 0)
            $display("tapered_clip_limiter_tb: PASS");
        else
            $display("tapered_clip_limiter_tb: FAIL");
        $finish;
    end

endmodule
